/* rtl/core/fpfa_pkg.sv */
// Shared types and constants for the fixed-partition fit allocator.
// Holds the word layouts, mode and register codes and controller links.
// No dependencies.
package fpfa_pkg;

  // Default sizing handed to the top level
  localparam int NUM_PARTS_DEF = 16;
  localparam int SIZE_BITS_DEF = 16;

  // Fixed field widths of the word layouts
  localparam int AMOUNT_W   = 16;
  localparam int PART_IDX_W = 4;
  localparam int PIU_W      = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int MODE_W     = 2;

  // Partitions in use after reset
  localparam logic [PIU_W-1:0] PIU_RESET = PIU_W'(16);

  // Item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // Placement modes
  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIT_MODE     = 1'b0,
    REG_PARTS_IN_USE = 1'b1
  } cfg_reg_t;

  // Input word
  typedef struct packed {
    logic                  kind;
    logic [PART_IDX_W-1:0] part_index;
    logic [AMOUNT_W-1:0]   amount;
  } req_word_t;

  // Result word
  typedef struct packed {
    logic                  found;
    logic [PART_IDX_W-1:0] chosen_index;
  } res_word_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic init;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_end;
  } dp_stat_t;

endpackage

/* rtl/core/fixed_partition_fit_allocator.sv */
// Top level of the fixed-partition fit allocator.
// Instantiates fpfa_ctrl and fpfa_datapath; depends on fpfa_pkg.
//
// A load word gives no result; busy stays low. A request word holds busy high
// while it scans N partitions, where N is partitions_in_use clamped to
// NUM_PARTS, and then commits; its result appears with done in the same cycle
// that busy drops, and the next word may be started in that same cycle. The
// scan reads the size memory once per cycle over all N partitions in every
// mode, so N sets how long busy stays high.
// Results are shown for one cycle only and the receiver cannot hold them off.
// Configuration is to be written through cfg_write, cfg_index and cfg_data
// only while busy is low; the block itself does not enforce this.
module fixed_partition_fit_allocator
  import fpfa_pkg::*;
#(
  parameter int NUM_PARTS = NUM_PARTS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  req_word_t             request,
  output logic                  done,
  output res_word_t             result
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  fpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (request.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Storage and compare
  fpfa_datapath #(
    .NUM_PARTS (NUM_PARTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule

/* rtl/core/fpfa_ctrl.sv */
// Sequencer for the fit allocator: accepts words and steps a request
// through scan and commit. Depends on fpfa_pkg.
module fpfa_ctrl
  import fpfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      kind,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (kind == KIND_REQUEST) begin
            cmd.init   = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/fpfa_datapath.sv */
// Datapath of the fit allocator: size memory, allocated marks, scan
// pointer, candidate compare and result register. Depends on fpfa_pkg.
module fpfa_datapath
  import fpfa_pkg::*;
#(
  parameter int NUM_PARTS = NUM_PARTS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  req_word_t             request,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  output logic                  done,
  output res_word_t             result
);

  localparam int IW = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int CW = $clog2(NUM_PARTS + 1);

  // Configuration
  fit_mode_t        fit_mode;
  logic [PIU_W-1:0] parts_in_use;

  // Stored state
  logic [SIZE_BITS-1:0] size_mem [NUM_PARTS];
  logic [NUM_PARTS-1:0] taken;
  logic [IW-1:0]        next_start;

  // Scan state
  logic [SIZE_BITS-1:0] want;
  logic [CW-1:0]        count;
  logic [CW-1:0]        issued;
  logic [IW-1:0]        scan_idx;
  logic                 cmp_vld;
  logic [IW-1:0]        cmp_idx;
  logic [SIZE_BITS-1:0] rd_size;
  logic                 rd_taken;
  logic                 hit;
  logic [IW-1:0]        pick;
  logic [SIZE_BITS-1:0] pick_size;

  logic                 load_ok;
  logic [IW-1:0]        load_idx;
  logic [CW-1:0]        count_sat;
  logic [IW-1:0]        start_idx;
  logic                 issue;
  logic [CW-1:0]        scan_inc;
  logic [IW-1:0]        scan_idx_next;
  logic                 fits;
  logic                 take;

  // Load address check and decode
  assign load_ok  = (32'(request.part_index) < NUM_PARTS);
  assign load_idx = IW'(request.part_index);

  // Clamp the scan count to the table depth
  assign count_sat = (32'(parts_in_use) > NUM_PARTS) ? CW'(NUM_PARTS) : CW'(parts_in_use);

  // Next fit resumes at the last pick when it lies inside the scan range
  assign start_idx = (fit_mode == FIT_NEXT && CW'(next_start) < count_sat) ? next_start
                                                                           : '0;

  // Advance the scan pointer circularly over the partitions in use
  assign issue         = cmd.scan && (issued != count);
  assign scan_inc      = CW'(scan_idx) + CW'(1);
  assign scan_idx_next = (scan_inc == count) ? '0 : IW'(scan_inc);
  assign stat.scan_end = (issued == count);

  // Candidate compare: first match wins unless a better size turns up
  assign fits = !rd_taken && (rd_size >= want);
  always_comb begin
    take = 1'b0;
    if (cmp_vld && fits) begin
      if (!hit) begin
        take = 1'b1;
      end else if (fit_mode == FIT_BEST && rd_size < pick_size) begin
        take = 1'b1;
      end else if (fit_mode == FIT_WORST && rd_size > pick_size) begin
        take = 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode     <= FIT_FIRST;
      parts_in_use <= PIU_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FIT_MODE:     fit_mode     <= fit_mode_t'(cfg_data[MODE_W-1:0]);
        REG_PARTS_IN_USE: parts_in_use <= PIU_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Size memory: one write on load, one registered read per scan step
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      size_mem[load_idx] <= SIZE_BITS'(request.amount);
    end
    if (issue) begin
      rd_size <= size_mem[scan_idx];
    end
  end

  // Allocated marks and next-fit pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      taken      <= '0;
      next_start <= '0;
    end else if (cmd.load && load_ok) begin
      taken[load_idx] <= 1'b0;
      next_start      <= '0;
    end else if (cmd.commit && hit) begin
      taken[pick] <= 1'b1;
      if (fit_mode == FIT_NEXT) begin
        next_start <= pick;
      end
    end
  end

  // Scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      cmp_vld <= issue;
      done    <= cmd.commit;
    end
  end

  // Scan payload: pointer, read tag, running best candidate
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      want     <= SIZE_BITS'(request.amount);
      count    <= count_sat;
      issued   <= '0;
      scan_idx <= start_idx;
      hit      <= 1'b0;
      pick     <= '0;
    end else begin
      if (issue) begin
        issued   <= issued + CW'(1);
        scan_idx <= scan_idx_next;
        cmp_idx  <= scan_idx;
        rd_taken <= taken[scan_idx];
      end
      if (take) begin
        hit       <= 1'b1;
        pick      <= cmp_idx;
        pick_size <= rd_size;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.found        <= hit;
      result.chosen_index <= hit ? PART_IDX_W'(pick) : '0;
    end
  end

endmodule

/* rtl/core/fpfa_checker.sv */
// Port-level checks for the fit allocator, bound to the top level.
// Depends on fpfa_pkg and fixed_partition_fit_allocator.
module fpfa_assertions
  import fpfa_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input req_word_t request,
  input logic      done,
  input res_word_t result
);

  // A request keeps the block busy in the next cycle
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.kind == KIND_REQUEST |=> busy)
    else $error("request accepted but block not busy");

  // A load completes in its own cycle
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.kind == KIND_LOAD |=> !busy)
    else $error("load held the block busy");

  // Finishing a request always shows its word
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("request finished without a result");

  // Results never come in consecutive cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

  // A miss reports index zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.chosen_index == '0)
    else $error("miss with non-zero index");

endmodule

bind fixed_partition_fit_allocator fpfa_assertions u_fpfa_assertions (.*);

/* dv/fpfa_checker.sv */
// Scoreboard for the fixed-partition fit allocator: watches the register port,
// the request channel and the result strobe, predicts and compares each word.
// Depends on fpfa_pkg.
module fpfa_checker
  import fpfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  input  logic                  busy,
  input  req_word_t             request,
  input  logic                  done,
  input  res_word_t             result,
  output int                    failures,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PARTS      = NUM_PARTS_DEF;
  localparam int PRINT_CAP  = 20;

  // Shadow of the partition table and registers
  logic [AMOUNT_W-1:0]   size_tab [PARTS];
  bit                    taken_tab [PARTS];
  logic [PART_IDX_W-1:0] nf_start;
  fit_mode_t             mode_q;
  logic [PIU_W-1:0]      span_q;

  res_word_t alloc_q [$];
  int        errs = 0;

  task automatic report_mismatch(input string msg);
    errs++;
    if (errs <= PRINT_CAP)
      $display("[%0t] allocator mismatch: %s", $time, msg);
  endtask

  function automatic bit slot_fits(input int i, input logic [AMOUNT_W-1:0] want);
    return !taken_tab[i] && size_tab[i] >= want;
  endfunction

  // Choose a partition for one request word and mark it allocated
  task automatic place_request(input logic [AMOUNT_W-1:0] want, output res_word_t res);
    int span;
    int j;
    int k;
    int pick;
    bit hit;
    span = (span_q > PARTS) ? PARTS : int'(span_q);
    hit  = 1'b0;
    pick = 0;
    if (mode_q == FIT_NEXT) begin
      // circular scan from the pointer, which falls back to 0 when out of range
      j = (nf_start < span) ? int'(nf_start) : 0;
      for (k = 0; k < span; k++) begin
        if (!hit && slot_fits(j, want)) begin
          hit  = 1'b1;
          pick = j;
        end
        j = (j + 1 == span) ? 0 : j + 1;
      end
    end else begin
      // ties keep the lowest index, since only a strict compare replaces the pick
      for (k = 0; k < span; k++) begin
        if (slot_fits(k, want)) begin
          if (!hit) begin
            hit  = 1'b1;
            pick = k;
          end else if (mode_q == FIT_BEST && size_tab[k] < size_tab[pick]) begin
            pick = k;
          end else if (mode_q == FIT_WORST && size_tab[k] > size_tab[pick]) begin
            pick = k;
          end
        end
      end
    end
    if (hit) begin
      taken_tab[pick] = 1'b1;
      if (mode_q == FIT_NEXT)
        nf_start = pick[PART_IDX_W-1:0];
    end
    res.found        = hit;
    res.chosen_index = hit ? pick[PART_IDX_W-1:0] : '0;
  endtask

  always @(posedge clk) begin
    res_word_t want;
    if (rst) begin
      for (int i = 0; i < PARTS; i++) begin
        size_tab[i]  = '0;
        taken_tab[i] = 1'b0;
      end
      nf_start = '0;
      mode_q   = FIT_FIRST;
      span_q   = PIU_RESET;
      alloc_q.delete();
    end else begin
      // compare the result word with the oldest prediction
      if (done) begin
        if (alloc_q.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending (found=%0b index=%0d)",
                                    result.found, result.chosen_index));
        end else begin
          want = alloc_q.pop_front();
          if (result.found !== want.found)
            report_mismatch($sformatf("found %0b, predicted %0b", result.found, want.found));
          if (result.chosen_index !== want.chosen_index)
            report_mismatch($sformatf("chosen_index %0d, predicted %0d",
                                      result.chosen_index, want.chosen_index));
        end
      end

      // track register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_FIT_MODE:     mode_q = fit_mode_t'(cfg_data[MODE_W-1:0]);
          REG_PARTS_IN_USE: span_q = cfg_data;
          default: ;
        endcase
      end

      // advance the shadow on each accepted word
      if (start && !busy) begin
        if (request.kind == KIND_LOAD) begin
          size_tab[request.part_index]  = request.amount;
          taken_tab[request.part_index] = 1'b0;
          nf_start = '0;
        end else begin
          place_request(request.amount, want);
          alloc_q.push_back(want);
        end
      end
    end
    pending  <= alloc_q.size();
    failures <= errs;
  end

endmodule

/* dv/fixed_partition_fit_allocator_tb.sv */
// Stimulus and verdict for the fixed-partition fit allocator.
// Drives register settings and load/request words; checking sits in fpfa_checker.
// Depends on fpfa_pkg, fpfa_checker and the allocator RTL.
module fixed_partition_fit_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpfa_pkg::*;

  localparam int PARTS          = NUM_PARTS_DEF;
  localparam int MAX_GAP        = 14;
  localparam int DRAIN_CYCLES   = PARTS + 8;
  localparam int RANDOM_WORDS   = 2000;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  start;
  logic                  busy;
  req_word_t             request;
  logic                  done;
  res_word_t             result;
  int                    failures;
  int                    pending;

  // Stimulus bookkeeping for request sizes, load indexes, the final counts and the watchdog
  logic [AMOUNT_W-1:0] loaded_size [PARTS];
  int                  reach = PARTS;
  int                  loads = 0;
  int                  requests = 0;
  int                  settings = 0;
  int                  idle_cycles = 0;

  fixed_partition_fit_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result)
  );

  fpfa_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // End the run if no word moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** fixed_partition_fit_allocator: FAILED **");
        $finish;
      end
    end
  end

  function automatic req_word_t load_of(input int idx, input logic [AMOUNT_W-1:0] amt);
    req_word_t w;
    w.kind       = KIND_LOAD;
    w.part_index = PART_IDX_W'(idx);
    w.amount     = amt;
    return w;
  endfunction

  // part_index is random on requests, since the block ignores it there
  function automatic req_word_t ask_of(input logic [AMOUNT_W-1:0] amt);
    req_word_t w;
    w.kind       = KIND_REQUEST;
    w.part_index = PART_IDX_W'($urandom_range(0, PARTS - 1));
    w.amount     = amt;
    return w;
  endfunction

  // Hold start until the word is taken; start stays high for a back-to-back word
  task automatic send_word(input req_word_t w, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= w;
    do @(posedge clk); while (busy);
    if (w.kind == KIND_LOAD) begin
      loads++;
      loaded_size[w.part_index] = w.amount;
    end else begin
      requests++;
    end
  endtask

  // Drop start, wait for every pending result, then let any load finish
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers; the mode word sometimes carries junk upper bits
  task automatic write_settings(input fit_mode_t m, input logic [PIU_W-1:0] span);
    logic [2:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
    cfg_write <= 1'b1;
    cfg_index <= REG_FIT_MODE;
    cfg_data  <= {junk, m};
    @(posedge clk);
    cfg_index <= REG_PARTS_IN_USE;
    cfg_data  <= span;
    @(posedge clk);
    cfg_write <= 1'b0;
    reach = (span == 0 || span > PARTS) ? PARTS : int'(span);
    settings++;
  endtask

  initial begin
    logic [AMOUNT_W-1:0] seed_sizes [PARTS];
    logic [AMOUNT_W-1:0] amt;
    logic [AMOUNT_W-1:0] base;
    logic [PIU_W-1:0]    span;
    req_word_t           w;
    int                  sent;
    int                  phase_len;
    int                  n;
    bit                  quiet;

    seed_sizes = '{16'd0, 16'd100, 16'hFFFF, 16'd100, 16'd5000, 16'd20, 16'd100, 16'hFFFE,
                   16'd300, 16'd5000, 16'd1, 16'd7, 16'd40000, 16'd20, 16'd999, 16'd100};
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_FIT_MODE;
    cfg_data  = '0;
    start     = 1'b0;
    request   = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load every partition first so no scan ever reads an unwritten size
    for (int i = 0; i < PARTS; i++)
      send_word(load_of(i, seed_sizes[i]), $urandom_range(0, MAX_GAP));

    // First fit at reset settings: zero size, largest size, and a miss
    send_word(ask_of(16'd0), 0);
    send_word(ask_of(16'hFFFF), $urandom_range(0, MAX_GAP));
    send_word(ask_of(16'hFFFF), 0);
    settle();
    write_settings(FIT_BEST, 5'd16);
    send_word(ask_of(16'd100), 0);
    settle();
    write_settings(FIT_WORST, 5'd16);
    send_word(ask_of(16'd0), 0);
    // Nothing scanned when no partitions are in use
    settle();
    write_settings(FIT_FIRST, 5'd0);
    send_word(ask_of(16'd1), 0);
    // Oversized scan count saturates; next fit moves the pointer
    settle();
    write_settings(FIT_NEXT, 5'd31);
    send_word(ask_of(16'd5000), 0);
    // Pointer beyond the scan range wraps to 0; a load sends it back to 0
    settle();
    write_settings(FIT_NEXT, 5'd3);
    send_word(ask_of(16'd1), 0);
    send_word(load_of(1, 16'd100), $urandom_range(0, MAX_GAP));
    send_word(ask_of(16'd50), 0);

    // Random phases, each under fresh register settings
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      settle();
      case ($urandom_range(0, 19))
        0:             span = 5'd0;
        1, 2:          span = 5'($urandom_range(17, 31));
        3, 4:          span = 5'd1;
        5, 6, 7, 8, 9: span = 5'd16;
        default:       span = 5'($urandom_range(2, 15));
      endcase
      write_settings(fit_mode_t'($urandom_range(0, 3)), span);
      phase_len = $urandom_range(20, 120);
      quiet     = ($urandom_range(0, 3) == 0);
      for (n = 0; n < phase_len && sent < RANDOM_WORDS; n++) begin
        // occasionally hold off until the block has answered everything
        if ($urandom_range(0, 49) == 0)
          settle();
        if ($urandom_range(0, 99) < 35) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: amt = AMOUNT_W'($urandom);
            5, 6, 7:       amt = AMOUNT_W'($urandom_range(0, 7) * 1024);
            8:             amt = '0;
            default:       amt = '1;
          endcase
          w = load_of(($urandom_range(0, 3) != 0) ? $urandom_range(0, reach - 1)
                                                   : $urandom_range(0, PARTS - 1), amt);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              // aim at a loaded size so hits and ties are common
              base = loaded_size[$urandom_range(0, reach - 1)];
              amt  = base - ((base > 3) ? AMOUNT_W'($urandom_range(0, 3)) : '0);
            end
            4, 5:    amt = AMOUNT_W'($urandom_range(0, 1000));
            6, 7:    amt = AMOUNT_W'($urandom);
            8:       amt = '0;
            default: amt = '1;
          endcase
          w = ask_of(amt);
        end
        send_word(w, quiet ? 0 : $urandom_range(0, MAX_GAP));
        sent++;
      end
    end
    settle();

    $display("Covered %0d load words and %0d request words over %0d register settings,",
             loads, requests, settings);
    $display("all four fit modes, empty and oversized scan counts, and wrapped next-fit.");
    if (failures == 0) begin
      $display("** fixed_partition_fit_allocator: PASSED **");
    end else begin
      $display("%0d mismatches", failures);
      $display("** fixed_partition_fit_allocator: FAILED **");
    end
    $finish;
  end

endmodule
